>>> rtl/mvnb_pkg.sv
// Package for the mesh vertex normal builder: field widths, item structs,
// command classes and the control structs passed between the block's modules.
// Depends on nothing.
package mvnb_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VERT_BITS    = $clog2(MAX_VERTICES);
   localparam int COORD_BITS   = 24;
   localparam int NORMAL_BITS  = 16;
   localparam int FRAC_BITS    = NORMAL_BITS - 1;
   localparam int SUM_BITS     = 24;
   localparam int EDGE_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * EDGE_BITS;
   localparam int VEC_BITS     = PROD_BITS + 2;

   // Normalization: the largest magnitude is brought into [2^29, 2^30).
   localparam int NORM_TOP     = 30;
   localparam int SHIFT_COARSE = 4;
   localparam int SQ_BITS      = 2 * NORM_TOP;
   localparam int ACC_BITS     = SQ_BITS + 2;
   localparam int BIT_BITS     = ACC_BITS - 1;
   localparam int LEN_BITS     = NORM_TOP + 1;
   localparam int QUO_BITS     = FRAC_BITS + 2;
   localparam int DIV_BITS     = LEN_BITS + QUO_BITS - 1;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_TRI    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [VERT_BITS-1:0]         vertex_index;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic [VERT_BITS-1:0]         corner_a;
      logic [VERT_BITS-1:0]         corner_b;
      logic [VERT_BITS-1:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [VERT_BITS-1:0]          normal_slot;
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
      logic                          degenerate;
   } rsp_type;

   typedef enum logic [1:0] {
      K_NONE = 2'd0,
      K_LOAD = 2'd1,
      K_TRI  = 2'd2,
      K_READ = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [VERT_BITS-1:0]         vertex_index;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic [VERT_BITS-1:0]         corner_a;
      logic [VERT_BITS-1:0]         corner_b;
      logic [VERT_BITS-1:0]         corner_c;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } pos_entry_type;

   typedef struct packed {
      logic                       poison;
      logic signed [SUM_BITS-1:0] sum_x;
      logic signed [SUM_BITS-1:0] sum_y;
      logic signed [SUM_BITS-1:0] sum_z;
   } sum_entry_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic                       start;
      logic signed [VEC_BITS-1:0] vec_x;
      logic signed [VEC_BITS-1:0] vec_y;
      logic signed [VEC_BITS-1:0] vec_z;
   } unit_req_type;

   typedef struct packed {
      logic                          done;
      logic                          zero;
      logic signed [NORMAL_BITS-1:0] unit_x;
      logic signed [NORMAL_BITS-1:0] unit_y;
      logic signed [NORMAL_BITS-1:0] unit_z;
   } unit_rsp_type;

endpackage

>>> rtl/mvnb_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module mvnb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> rtl/mvnb_front.sv
// Front end: accepts request items, classifies the opcode and queues commands.
// Depends on mvnb_pkg.
module mvnb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mvnb_pkg::req_type        req_data,
   input  mvnb_pkg::back_status_type status,
   output logic                     cmd_valid,
   output mvnb_pkg::cmd_type        cmd,
   input  logic                     cmd_pop
);
   import mvnb_pkg::*;

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   kind_type             kind;
   logic                 accept;
   logic                 push;

   always_comb begin
      unique case (req_data.opcode)
         OP_LOAD: kind = K_LOAD;
         OP_TRI:  kind = K_TRI;
         OP_READ: kind = K_READ;
         default: kind = K_NONE;
      endcase
   end

   assign req_stall = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH)) || status.clearing;
   assign accept    = req_valid && !req_stall;
   // The unused opcode is taken and dropped here.
   assign push      = accept && (kind != K_NONE);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{kind: kind, vertex_index: req_data.vertex_index,
                              coord_x: req_data.coord_x, coord_y: req_data.coord_y,
                              coord_z: req_data.coord_z, corner_a: req_data.corner_a,
                              corner_b: req_data.corner_b, corner_c: req_data.corner_c};
      end
   end
endmodule

>>> rtl/mvnb_unit.sv
// Iterative unit-vector unit: magnitude scaling, sum of squares, bitwise integer
// square root and restoring division for each component. Depends on mvnb_pkg.
module mvnb_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  mvnb_pkg::unit_req_type unit_req,
   output mvnb_pkg::unit_rsp_type unit_rsp
);
   import mvnb_pkg::*;

   typedef enum logic [5:0] {
      U_IDLE  = 6'b000001,
      U_SHIFT = 6'b000010,
      U_SQ    = 6'b000100,
      U_ROOT  = 6'b001000,
      U_DLOAD = 6'b010000,
      U_DIV   = 6'b100000
   } ustate_type;

   ustate_type                    state_ff;
   logic [VEC_BITS-1:0]           m_ff [3];
   logic                          neg_ff [3];
   logic [SQ_BITS-1:0]            sq_ff;
   logic [ACC_BITS-1:0]           acc_ff;
   logic [ACC_BITS-1:0]           rem_root_ff;
   logic [ACC_BITS-1:0]           root_ff;
   logic [BIT_BITS-1:0]           bit_ff;
   logic [LEN_BITS-1:0]           len_ff;
   logic [DIV_BITS-1:0]           rem_ff;
   logic [DIV_BITS-1:0]           dsh_ff;
   logic [QUO_BITS-1:0]           q_ff;
   logic [1:0]                    comp_ff;
   logic [4:0]                    cnt_ff;
   logic signed [NORMAL_BITS-1:0] u_ff [3];
   logic                          zero_ff;
   logic                          done_ff;

   logic [VEC_BITS-1:0]   start_m [3];
   logic [VEC_BITS-1:0]   top;
   logic [VEC_BITS-1:0]   start_top;
   logic [ACC_BITS:0]     trial;
   logic [ACC_BITS-1:0]   root_next;
   logic [QUO_BITS-1:0]   q_next;
   logic [QUO_BITS-1:0]   q_clamp;
   logic [NORMAL_BITS-1:0] u_val;

   function automatic logic [VEC_BITS-1:0] mag(input logic signed [VEC_BITS-1:0] v);
      return v[VEC_BITS-1] ? VEC_BITS'(0) - VEC_BITS'(v) : VEC_BITS'(v);
   endfunction

   function automatic logic [VEC_BITS-1:0] max3(input logic [VEC_BITS-1:0] a,
                                                input logic [VEC_BITS-1:0] b,
                                                input logic [VEC_BITS-1:0] c);
      logic [VEC_BITS-1:0] t;
      t = (a > b) ? a : b;
      return (c > t) ? c : t;
   endfunction

   always_comb begin
      start_m[0] = mag(unit_req.vec_x);
      start_m[1] = mag(unit_req.vec_y);
      start_m[2] = mag(unit_req.vec_z);
      start_top  = max3(start_m[0], start_m[1], start_m[2]);
      top        = max3(m_ff[0], m_ff[1], m_ff[2]);
      trial      = {1'b0, root_ff} + (ACC_BITS+1)'(bit_ff);
      root_next  = ({1'b0, rem_root_ff} >= trial) ? (root_ff >> 1) + ACC_BITS'(bit_ff)
                                                  : root_ff >> 1;
      q_next     = (rem_ff >= dsh_ff) ? {q_ff[QUO_BITS-2:0], 1'b1}
                                      : {q_ff[QUO_BITS-2:0], 1'b0};
      if (neg_ff[comp_ff]) begin
         q_clamp = (q_next > QUO_BITS'(1 << FRAC_BITS)) ? QUO_BITS'(1 << FRAC_BITS) : q_next;
         u_val   = NORMAL_BITS'(QUO_BITS'(0) - q_clamp);
      end else begin
         q_clamp = (q_next > QUO_BITS'((1 << FRAC_BITS) - 1))
                   ? QUO_BITS'((1 << FRAC_BITS) - 1) : q_next;
         u_val   = q_clamp[NORMAL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            U_IDLE: begin
               if (unit_req.start) begin
                  // Operands are captured as magnitudes with their signs kept aside.
                  for (int i = 0; i < 3; i++) m_ff[i] <= start_m[i];
                  neg_ff[0] <= unit_req.vec_x[VEC_BITS-1];
                  neg_ff[1] <= unit_req.vec_y[VEC_BITS-1];
                  neg_ff[2] <= unit_req.vec_z[VEC_BITS-1];
                  if (start_top == '0) begin
                     zero_ff <= 1'b1;
                     done_ff <= 1'b1;
                  end else begin
                     zero_ff  <= 1'b0;
                     state_ff <= U_SHIFT;
                  end
               end
            end
            U_SHIFT: begin
               if (top[VEC_BITS-1:NORM_TOP+SHIFT_COARSE] != '0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> SHIFT_COARSE;
               end else if (top[VEC_BITS-1:NORM_TOP] != '0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end else if (top[VEC_BITS-1:NORM_TOP-1-SHIFT_COARSE] == '0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << SHIFT_COARSE;
               end else if (top[VEC_BITS-1:NORM_TOP-1] == '0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               end else begin
                  cnt_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= U_SQ;
               end
            end
            U_SQ: begin
               if (cnt_ff < 5'd3) begin
                  sq_ff <= m_ff[cnt_ff[1:0]][NORM_TOP-1:0] * m_ff[cnt_ff[1:0]][NORM_TOP-1:0];
               end
               if (cnt_ff != '0) begin
                  acc_ff <= acc_ff + ACC_BITS'(sq_ff);
               end
               if (cnt_ff == 5'd3) begin
                  rem_root_ff <= acc_ff + ACC_BITS'(sq_ff);
                  root_ff     <= '0;
                  bit_ff      <= {1'b1, {(BIT_BITS-1){1'b0}}};
                  state_ff    <= U_ROOT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            U_ROOT: begin
               if ({1'b0, rem_root_ff} >= trial) begin
                  rem_root_ff <= rem_root_ff - trial[ACC_BITS-1:0];
               end
               root_ff <= root_next;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  len_ff   <= root_next[LEN_BITS-1:0];
                  comp_ff  <= '0;
                  state_ff <= U_DLOAD;
               end
            end
            U_DLOAD: begin
               rem_ff   <= DIV_BITS'({m_ff[comp_ff][NORM_TOP-1:0], {FRAC_BITS{1'b0}}})
                           + DIV_BITS'(len_ff >> 1);
               dsh_ff   <= DIV_BITS'(len_ff) << (QUO_BITS - 1);
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= U_DIV;
            end
            U_DIV: begin
               if (rem_ff >= dsh_ff) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               q_ff   <= q_next;
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(QUO_BITS - 1)) begin
                  u_ff[comp_ff] <= u_val;
                  if (comp_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= U_IDLE;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= U_DLOAD;
                  end
               end
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

   assign unit_rsp = '{done: done_ff, zero: zero_ff,
                       unit_x: u_ff[0], unit_y: u_ff[1], unit_z: u_ff[2]};
endmodule

>>> rtl/mvnb_back.sv
// Back end: owns the position and sum memories, runs the clearing pass, the
// triangle and read sequences, and holds the result register. Depends on
// mvnb_pkg and mvnb_ram.
module mvnb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  mvnb_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   output mvnb_pkg::back_status_type status,
   output mvnb_pkg::unit_req_type    unit_req,
   input  mvnb_pkg::unit_rsp_type    unit_rsp,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mvnb_pkg::rsp_type         rsp_data
);
   import mvnb_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_PRD   = 12'b000000000100,
      S_EDGE  = 12'b000000001000,
      S_CROSS = 12'b000000010000,
      S_UNIT  = 12'b000000100000,
      S_SRD   = 12'b000001000000,
      S_SWR   = 12'b000010000000,
      S_RRD   = 12'b000100000000,
      S_RWAIT = 12'b001000000000,
      S_RUNIT = 12'b010000000000,
      S_RSP   = 12'b100000000000
   } state_type;

   state_type                     state_ff;
   logic [VERT_BITS-1:0]          cnt_ff;
   cmd_type                       cmd_ff;
   pos_entry_type                 pos_ff [3];
   logic signed [EDGE_BITS-1:0]   e1_ff [3];
   logic signed [EDGE_BITS-1:0]   e2_ff [3];
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   hold_ff;
   logic signed [VEC_BITS-1:0]    n_ff [3];
   logic                          zero_ff;
   logic signed [NORMAL_BITS-1:0] u_ff [3];
   rsp_type                       res_ff;
   rsp_type                       rsp_ff;
   logic                          rsp_valid_ff;

   logic                          pos_we, pos_re, sum_we, sum_re;
   logic [VERT_BITS-1:0]          pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   pos_entry_type                 pos_wdata, pos_rdata;
   sum_entry_type                 sum_wdata, sum_rdata;
   logic [VERT_BITS-1:0]          corner;
   logic signed [EDGE_BITS-1:0]   mul_a, mul_b;
   logic                          rsp_free;
   rsp_type                       rsp_default;

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]    a,
      input logic signed [NORMAL_BITS-1:0] b);
      logic signed [SUM_BITS:0] s;
      s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
      if (s > (SUM_BITS+1)'((1 << (SUM_BITS-1)) - 1)) begin
         return SUM_BITS'((1 << (SUM_BITS-1)) - 1);
      end else if (s < -(SUM_BITS+1)'(1 << (SUM_BITS-1))) begin
         return SUM_BITS'(1 << (SUM_BITS-1));
      end
      return s[SUM_BITS-1:0];
   endfunction

   mvnb_ram #(.WIDTH($bits(pos_entry_type)), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_waddr), .wr_data(pos_wdata),
      .rd_en(pos_re), .rd_addr(pos_raddr), .rd_data(pos_rdata));

   mvnb_ram #(.WIDTH($bits(sum_entry_type)), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(sum_wdata),
      .rd_en(sum_re), .rd_addr(sum_raddr), .rd_data(sum_rdata));

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_default = '{normal_slot: cmd_ff.vertex_index, normal_x: '0, normal_y: '0,
                          normal_z: NORMAL_BITS'((1 << FRAC_BITS) - 1), degenerate: 1'b1};

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    corner = cmd_ff.corner_a;
         2'd1:    corner = cmd_ff.corner_b;
         default: corner = cmd_ff.corner_c;
      endcase
      case (cnt_ff[2:0])
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
   end

   // Queue pop, memory ports and the normalize request.
   always_comb begin
      cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
      pos_we    = cmd_pop && (cmd.kind == K_LOAD);
      pos_waddr = cmd.vertex_index;
      pos_wdata = '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
      pos_re    = (state_ff == S_PRD) && (cnt_ff < VERT_BITS'(3));
      pos_raddr = corner;
      sum_re    = (state_ff == S_SRD) || (state_ff == S_RRD);
      sum_raddr = (state_ff == S_RRD) ? cmd_ff.vertex_index : corner;
      sum_we    = 1'b0;
      sum_waddr = cnt_ff;
      sum_wdata = '0;
      if (state_ff == S_CLEAR) begin
         sum_we = 1'b1;
      end else if (pos_we) begin
         sum_we    = 1'b1;
         sum_waddr = cmd.vertex_index;
      end else if (state_ff == S_SWR) begin
         sum_we    = 1'b1;
         sum_waddr = corner;
         sum_wdata = sum_rdata;
         if (zero_ff) begin
            sum_wdata.poison = 1'b1;
         end else begin
            sum_wdata.sum_x = sat_add(sum_rdata.sum_x, u_ff[0]);
            sum_wdata.sum_y = sat_add(sum_rdata.sum_y, u_ff[1]);
            sum_wdata.sum_z = sat_add(sum_rdata.sum_z, u_ff[2]);
         end
      end
      unit_req = '{start: ((state_ff == S_UNIT) || (state_ff == S_RUNIT)) && (cnt_ff == '0),
                   vec_x: n_ff[0], vec_y: n_ff[1], vec_z: n_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == VERT_BITS'(MAX_VERTICES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               cnt_ff <= '0;
               if (cmd_valid) begin
                  case (cmd.kind)
                     K_TRI:   state_ff <= S_PRD;
                     K_READ:  state_ff <= S_RRD;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_PRD: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == VERT_BITS'(3)) begin
                  state_ff <= S_EDGE;
               end
            end
            S_EDGE: begin
               cnt_ff   <= '0;
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == VERT_BITS'(6)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_UNIT;
               end
            end
            S_UNIT: begin
               cnt_ff <= VERT_BITS'(1);
               if (unit_rsp.done) begin
                  cnt_ff   <= '0;
                  state_ff <= S_SRD;
               end
            end
            S_SRD: state_ff <= S_SWR;
            S_SWR: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == VERT_BITS'(2)) ? S_IDLE : S_SRD;
            end
            S_RRD: state_ff <= S_RWAIT;
            S_RWAIT: begin
               cnt_ff   <= '0;
               state_ff <= sum_rdata.poison ? S_RSP : S_RUNIT;
            end
            S_RUNIT: begin
               cnt_ff <= VERT_BITS'(1);
               if (unit_rsp.done) begin
                  state_ff <= S_RSP;
               end
            end
            S_RSP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (state_ff == S_PRD && cnt_ff != '0) begin
         pos_ff[cnt_ff[1:0] - 2'd1] <= pos_rdata;
      end
      if (state_ff == S_EDGE) begin
         e1_ff[0] <= EDGE_BITS'(pos_ff[1].x) - EDGE_BITS'(pos_ff[0].x);
         e1_ff[1] <= EDGE_BITS'(pos_ff[1].y) - EDGE_BITS'(pos_ff[0].y);
         e1_ff[2] <= EDGE_BITS'(pos_ff[1].z) - EDGE_BITS'(pos_ff[0].z);
         e2_ff[0] <= EDGE_BITS'(pos_ff[2].x) - EDGE_BITS'(pos_ff[0].x);
         e2_ff[1] <= EDGE_BITS'(pos_ff[2].y) - EDGE_BITS'(pos_ff[0].y);
         e2_ff[2] <= EDGE_BITS'(pos_ff[2].z) - EDGE_BITS'(pos_ff[0].z);
      end
      if (state_ff == S_CROSS) begin
         prod_ff <= mul_a * mul_b;
         if (cnt_ff != '0) begin
            if (!cnt_ff[0]) begin
               n_ff[cnt_ff[2:1] - 2'd1] <= VEC_BITS'(hold_ff) - VEC_BITS'(prod_ff);
            end else begin
               hold_ff <= prod_ff;
            end
         end
      end
      if (state_ff == S_UNIT && unit_rsp.done) begin
         zero_ff <= unit_rsp.zero;
         u_ff[0] <= unit_rsp.unit_x;
         u_ff[1] <= unit_rsp.unit_y;
         u_ff[2] <= unit_rsp.unit_z;
      end
      // A finished read is staged in res_ff so that a result still waiting
      // in the output register is not disturbed.
      if (state_ff == S_RWAIT) begin
         n_ff[0] <= VEC_BITS'(sum_rdata.sum_x);
         n_ff[1] <= VEC_BITS'(sum_rdata.sum_y);
         n_ff[2] <= VEC_BITS'(sum_rdata.sum_z);
         if (sum_rdata.poison) begin
            res_ff <= rsp_default;
         end
      end
      if (state_ff == S_RUNIT && unit_rsp.done) begin
         if (unit_rsp.zero) begin
            res_ff <= rsp_default;
         end else begin
            res_ff <= '{normal_slot: cmd_ff.vertex_index, normal_x: unit_rsp.unit_x,
                        normal_y: unit_rsp.unit_y, normal_z: unit_rsp.unit_z,
                        degenerate: 1'b0};
         end
      end
      if (state_ff == S_RSP && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign status    = '{clearing: (state_ff == S_CLEAR)};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !cmd_pop)
      else $error("command taken during the clearing pass");

   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == S_UNIT || state_ff == S_RUNIT))
      else $error("normalize unit finished while nobody waits");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP) && rsp_free |=> rsp_valid_ff)
      else $error("result not presented after a read completed");
endmodule

>>> rtl/mesh_vertex_normal_builder.sv
// Top level of the mesh vertex normal builder: front end, back end and the
// shared normalize unit. Depends on mvnb_pkg, mvnb_front, mvnb_back, mvnb_unit.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries one item
// per handshake: a vertex load, a triangle or a normal read; the unused opcode
// is taken and dropped. Only a read produces a result item on the response
// channel (rsp_valid, rsp_stall, rsp_data).
// Items are queued two deep by the front end and executed one at a time by
// the back end. A load is written to both memories as it is popped. A
// triangle takes three position reads, six sequential multiplies on one
// multiplier, then the normalize unit (scaling shifts, three squares, a 31-step
// square root and three 17-step divisions), then three read-modify-writes of
// the sum memory. A degenerate face skips the unit's scaling, squares, root
// and divisions. A read of a poisoned vertex skips the unit; for a zero sum
// the unit skips the same steps, and any other sum is normalized in full.
// After reset the back end sweeps the sum memory, one entry per cycle,
// clearing sums and poison marks; req_stall is high during that pass.
// A finished result waits in the output register while the receiver stalls;
// the back end keeps executing loads and triangles behind it and only a
// second read waits for that register to drain.
module mesh_vertex_normal_builder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mvnb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mvnb_pkg::rsp_type rsp_data
);
   import mvnb_pkg::*;

   back_status_type status;
   cmd_type         cmd;
   logic            cmd_valid;
   logic            cmd_pop;
   unit_req_type    unit_req;
   unit_rsp_type    unit_rsp;

   // Front end: decode and queue.
   mvnb_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .status(status), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

   // Back end: memories, sequencing and the result register.
   mvnb_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .status(status),
      .unit_req(unit_req), .unit_rsp(unit_rsp),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

   // Normalize unit, shared by face normals and vertex reads.
   mvnb_unit u_unit (
      .clock(clock), .reset(reset), .unit_req(unit_req), .unit_rsp(unit_rsp));
endmodule
